// ----- hw/rtl/dasc_pkg.sv -----
// Shared types and constants for the dual actuator sync controller.
// No dependencies.
package dasc_pkg;

   localparam int POSITION_BITS_DEF = 16;
   localparam int TOL_BITS          = 8;
   localparam int OUT_BITS          = 16;

   localparam logic [TOL_BITS-1:0] TOL_RESET = 8'd1;

   localparam logic [2:0] OP_SAMPLE  = 3'd0;
   localparam logic [2:0] OP_STOP    = 3'd1;
   localparam logic [2:0] OP_RETRACT = 3'd2;
   localparam logic [2:0] OP_DEPLOY  = 3'd3;
   localparam logic [2:0] OP_PITCH   = 3'd4;

   typedef struct packed {
      logic [2:0] op;
      logic       sense_a;
      logic       sense_b;
      logic       pitch_leg;
   } req_type;

   typedef struct packed {
      logic                       drive_a_down;
      logic                       drive_a_up;
      logic                       drive_b_down;
      logic                       drive_b_up;
      logic signed [OUT_BITS-1:0] position_a;
      logic signed [OUT_BITS-1:0] position_b;
      logic signed [OUT_BITS-1:0] position_gap;
   } rsp_type;

endpackage

// ----- hw/rtl/dual_actuator_sync_controller.sv -----
// Top level: input register, state update core, tolerance register, result register.
// Depends on dasc_pkg, dasc_in_reg, dasc_core.
//
//   port group   dir   handshake            payload
//   req_         in    req_valid/req_ready  req_data (dasc_pkg::req_type)
//   rsp_         out   rsp_valid/rsp_ready  rsp_data (dasc_pkg::rsp_type)
//   csr_         in    csr_wr_en            csr_wr_data (sync tolerance)
//
// One request per cycle unless rsp_ready stalls; each passes the input register, then the result register.
// The response register and the input register let one request be taken
// while a response waits. Reset clears positions, levels, direction and
// drives, and sets the tolerance to one.
module dual_actuator_sync_controller #(
   parameter int POSITION_BITS = dasc_pkg::POSITION_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  dasc_pkg::req_type             req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output dasc_pkg::rsp_type             rsp_data,
   input  logic                          csr_wr_en,
   input  logic [dasc_pkg::TOL_BITS-1:0] csr_wr_data
);

   logic [dasc_pkg::TOL_BITS-1:0] tol_ff;
   logic                          hold_valid;
   dasc_pkg::req_type             hold_data;
   logic                          advance;
   dasc_pkg::rsp_type             core_result;
   logic                          rsp_valid_ff, rsp_valid_in;
   dasc_pkg::rsp_type             rsp_data_ff;

   assign advance      = hold_valid && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_data_ff;

   dasc_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .take       (advance),
      .hold_valid (hold_valid),
      .hold_data  (hold_data)
   );

   dasc_core #(
      .POSITION_BITS (POSITION_BITS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .fire      (advance),
      .item      (hold_data),
      .tolerance (tol_ff),
      .result    (core_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff       <= dasc_pkg::TOL_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            tol_ff <= csr_wr_data;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
      if (advance) begin
         rsp_data_ff <= core_result;
      end
   end

endmodule

// ----- hw/rtl/dasc_in_reg.sv -----
// Input register stage for requests.
// Depends on dasc_pkg.
module dasc_in_reg (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  dasc_pkg::req_type req_data,
   input  logic             take,
   output logic             hold_valid,
   output dasc_pkg::req_type hold_data
);

   logic              valid_ff, valid_in;
   dasc_pkg::req_type data_ff;

   assign req_ready  = !valid_ff || take;
   assign valid_in   = (req_valid && req_ready) || (valid_ff && !take);
   assign hold_valid = valid_ff;
   assign hold_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (req_valid && req_ready) begin
         data_ff <= req_data;
      end
   end

endmodule

// ----- hw/rtl/dasc_core.sv -----
// Actuator state (positions, levels, direction, drives) and its update per request.
// Depends on dasc_pkg.
module dasc_core #(
   parameter int POSITION_BITS = dasc_pkg::POSITION_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           fire,
   input  dasc_pkg::req_type              item,
   input  logic [dasc_pkg::TOL_BITS-1:0]  tolerance,
   output dasc_pkg::rsp_type              result
);

   localparam int CW    = POSITION_BITS + dasc_pkg::TOL_BITS + 2;
   localparam int EXT_W = (POSITION_BITS > dasc_pkg::OUT_BITS) ?
                          POSITION_BITS : dasc_pkg::OUT_BITS;

   typedef enum logic [1:0] {
      DIR_STOP    = 2'd0,
      DIR_DEPLOY  = 2'd1,
      DIR_RETRACT = 2'd2
   } dir_type;

   // drive bit order: 0 A down, 1 A up, 2 B down, 3 B up
   localparam int DRV_A_DOWN = 0;
   localparam int DRV_A_UP   = 1;
   localparam int DRV_B_DOWN = 2;
   localparam int DRV_B_UP   = 3;

   logic [POSITION_BITS-1:0] cnt_a_ff, cnt_a_in;
   logic [POSITION_BITS-1:0] cnt_b_ff, cnt_b_in;
   logic                     prev_a_ff, prev_a_in;
   logic                     prev_b_ff, prev_b_in;
   dir_type                  dir_ff, dir_in;
   logic [3:0]               drv_ff, drv_in;

   logic [POSITION_BITS-1:0] diff;
   logic [EXT_W-1:0]         pos_a_ext, pos_b_ext, gap_ext;

   always_comb begin
      logic                     moving;
      logic [POSITION_BITS-1:0] step;
      logic [POSITION_BITS-1:0] d;
      logic signed [CW-1:0]     gap_s, tol_s, cut_s;

      cnt_a_in  = cnt_a_ff;
      cnt_b_in  = cnt_b_ff;
      prev_a_in = prev_a_ff;
      prev_b_in = prev_b_ff;
      dir_in    = dir_ff;
      drv_in    = drv_ff;
      moving    = (dir_ff == DIR_DEPLOY) || (dir_ff == DIR_RETRACT);
      step      = (dir_ff == DIR_DEPLOY) ? POSITION_BITS'(1) : '1;
      d         = '0;
      gap_s     = '0;
      tol_s     = signed'(CW'(tolerance));
      cut_s     = tol_s + tol_s;

      case (item.op)
         dasc_pkg::OP_SAMPLE: begin
            if (moving) begin
               if (item.sense_a && !prev_a_ff) begin
                  cnt_a_in = cnt_a_ff + step;
               end
               if (item.sense_b && !prev_b_ff) begin
                  cnt_b_in = cnt_b_ff + step;
               end
               prev_a_in = item.sense_a;
               prev_b_in = item.sense_b;
               d         = cnt_a_in - cnt_b_in;
               gap_s     = CW'(signed'(d));
               if (dir_ff == DIR_DEPLOY) begin
                  if (gap_s >= -tol_s && gap_s <= tol_s) begin
                     drv_in[DRV_A_DOWN] = 1'b1;
                     drv_in[DRV_B_DOWN] = 1'b1;
                  end else if (gap_s > cut_s) begin
                     drv_in[DRV_A_DOWN] = 1'b0;
                  end else if (gap_s < -cut_s) begin
                     drv_in[DRV_B_DOWN] = 1'b0;
                  end
               end else begin
                  if (gap_s >= -tol_s && gap_s <= tol_s) begin
                     drv_in[DRV_A_UP] = 1'b1;
                     drv_in[DRV_B_UP] = 1'b1;
                  end else if (gap_s < -cut_s) begin
                     drv_in[DRV_A_UP] = 1'b0;
                  end else if (gap_s > cut_s) begin
                     drv_in[DRV_B_UP] = 1'b0;
                  end
               end
            end
         end
         dasc_pkg::OP_STOP: begin
            dir_in = DIR_STOP;
            drv_in = '0;
         end
         dasc_pkg::OP_RETRACT: begin
            dir_in           = DIR_RETRACT;
            drv_in           = '0;
            drv_in[DRV_A_UP] = 1'b1;
            drv_in[DRV_B_UP] = 1'b1;
         end
         dasc_pkg::OP_DEPLOY: begin
            dir_in             = DIR_DEPLOY;
            drv_in             = '0;
            drv_in[DRV_A_DOWN] = 1'b1;
            drv_in[DRV_B_DOWN] = 1'b1;
         end
         dasc_pkg::OP_PITCH: begin
            dir_in   = DIR_STOP;
            cnt_a_in = '0;
            cnt_b_in = '0;
            drv_in   = '0;
            if (item.pitch_leg) begin
               drv_in[DRV_A_UP]   = 1'b1;
               drv_in[DRV_B_DOWN] = 1'b1;
            end else begin
               drv_in[DRV_A_DOWN] = 1'b1;
               drv_in[DRV_B_UP]   = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // result reflects the state after this request
   assign diff      = cnt_a_in - cnt_b_in;
   assign pos_a_ext = EXT_W'(cnt_a_in);
   assign pos_b_ext = EXT_W'(cnt_b_in);
   assign gap_ext   = EXT_W'(diff);

   always_comb begin
      result.drive_a_down = drv_in[DRV_A_DOWN];
      result.drive_a_up   = drv_in[DRV_A_UP];
      result.drive_b_down = drv_in[DRV_B_DOWN];
      result.drive_b_up   = drv_in[DRV_B_UP];
      result.position_a   = signed'(pos_a_ext[dasc_pkg::OUT_BITS-1:0]);
      result.position_b   = signed'(pos_b_ext[dasc_pkg::OUT_BITS-1:0]);
      result.position_gap = signed'(gap_ext[dasc_pkg::OUT_BITS-1:0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_a_ff  <= '0;
         cnt_b_ff  <= '0;
         prev_a_ff <= 1'b0;
         prev_b_ff <= 1'b0;
         dir_ff    <= DIR_STOP;
         drv_ff    <= '0;
      end else if (fire) begin
         cnt_a_ff  <= cnt_a_in;
         cnt_b_ff  <= cnt_b_in;
         prev_a_ff <= prev_a_in;
         prev_b_ff <= prev_b_in;
         dir_ff    <= dir_in;
         drv_ff    <= drv_in;
      end
   end

   a_stop_clears: assert property (@(posedge clock) disable iff (reset)
      fire && item.op == dasc_pkg::OP_STOP |=> drv_ff == '0 && dir_ff == DIR_STOP)
      else $error("stop left drives or direction set");

   a_idle_sample: assert property (@(posedge clock) disable iff (reset)
      fire && item.op == dasc_pkg::OP_SAMPLE && dir_ff == DIR_STOP
      |=> $stable(cnt_a_ff) && $stable(cnt_b_ff) && $stable(prev_a_ff) && $stable(prev_b_ff))
      else $error("sample changed state while stopped");

   a_pitch_zero: assert property (@(posedge clock) disable iff (reset)
      fire && item.op == dasc_pkg::OP_PITCH |=> cnt_a_ff == '0 && cnt_b_ff == '0)
      else $error("pitch did not zero positions");

   a_deploy_no_up: assert property (@(posedge clock) disable iff (reset)
      dir_ff == DIR_DEPLOY |-> !drv_ff[DRV_A_UP] && !drv_ff[DRV_B_UP])
      else $error("up drive on while deploying");

endmodule
